// ----- design/pgcf_pkg.sv -----
// Shared types, codes and constants of the pixel gain, clamp and FITS scaler.
package pgcf_pkg;

  // Command codes of an input item
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Status codes of a result item
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EXTRA = 2'd1;
  localparam logic [1:0] STAT_SHORT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_GAIN   = 3'd0;
  localparam logic [2:0] CFG_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_FRAMES = 3'd3;
  localparam logic [2:0] CFG_ZERO   = 3'd4;
  localparam logic [2:0] CFG_SCALE  = 3'd5;

  // Configuration reset values
  localparam logic [15:0] GAIN_RST   = 16'd1;
  localparam logic [14:0] WIDTH_RST  = 15'd0;
  localparam logic [14:0] HEIGHT_RST = 15'd0;
  localparam logic [15:0] FRAMES_RST = 16'd1;
  localparam logic [16:0] ZERO_RST   = 17'd32768;
  localparam logic [15:0] SCALE_RST  = 16'd256;

  // Sizes
  localparam int COUNT_BITS_DEF  = 44;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int PROD_BITS       = 30;
  localparam int TOTAL_BITS      = 46;
  localparam int OFF_BITS        = 12;
  localparam int BLOCK_BYTES     = 2880;
  localparam logic [OFF_BITS-1:0] BLOCK_BYTES_W = OFF_BITS'(BLOCK_BYTES);
  localparam logic [OFF_BITS-1:0] WORD_BYTES    = 12'd2;

  // Cycles for the cube total to follow a configuration write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // Configuration register file
  typedef struct packed {
    logic [15:0] software_gain;
    logic [14:0] frame_width;
    logic [14:0] frame_height;
    logic [15:0] frame_count;
    logic [16:0] zero_offset;
    logic [15:0] scale_q8;
  } cfg_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic        is_pixel;
    logic [31:0] raw;
    logic [1:0]  status;
    logic [11:0] pad;
  } q_entry_t;

endpackage

// ----- design/pixel_gain_clamp_fits_scaler.sv -----
// Top level of the pixel gain, clamp and FITS 16-bit scaler with cube counter.
//
// Items enter on in_valid/in_ready: in_opcode selects start of cube, pixel or
// end of cube, in_raw_pixel carries the signed raw pixel. Every item gives
// exactly one result on out_valid/out_ready: the int16 FITS word (send high
// byte first), a word-valid flag, a status code and, at a complete end of
// cube, the zero padding bytes up to the next 2880-byte block.
// Registers are written on cfg_valid/cfg_ready (always ready) by index; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Items are held off after a write while the cube total
// settles. In the back end, one shared divider produces two quotient bits a
// cycle, first for the gain divide and then for the scaling divide, between
// load, prepare and finish steps. A negative pixel skips the gain divide.
// Start, end, extra pixels and unused codes give their result straight from
// the idle state. Items pass a short command queue, and the back end takes
// one command at a time.
// Reset clears the counters, queue and output valid flag and restores the
// register defaults. When the receiver stalls, the result holds, the
// queue fills and then in_ready drops.
module pixel_gain_clamp_fits_scaler #(
  parameter int COUNT_BITS  = pgcf_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = pgcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_raw_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_scaled_word,
  output logic               out_word_valid,
  output logic [1:0]         out_status,
  output logic [11:0]        out_pad_bytes,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import pgcf_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     cfg_wr;
  logic     q_push, q_pop, q_full, q_not_empty;
  q_entry_t q_data, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Write the addressed configuration register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_GAIN:   cfg_nxt.software_gain = cfg_data[15:0];
        CFG_WIDTH:  cfg_nxt.frame_width   = cfg_data[14:0];
        CFG_HEIGHT: cfg_nxt.frame_height  = cfg_data[14:0];
        CFG_FRAMES: cfg_nxt.frame_count   = cfg_data[15:0];
        CFG_ZERO:   cfg_nxt.zero_offset   = cfg_data;
        CFG_SCALE:  cfg_nxt.scale_q8      = cfg_data[15:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.software_gain <= GAIN_RST;
      cfg_r.frame_width   <= WIDTH_RST;
      cfg_r.frame_height  <= HEIGHT_RST;
      cfg_r.frame_count   <= FRAMES_RST;
      cfg_r.zero_offset   <= ZERO_RST;
      cfg_r.scale_q8      <= SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pgcf_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cfg_wr       (cfg_wr),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_raw_pixel (in_raw_pixel),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  pgcf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pgcf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_scaled_word (out_scaled_word),
    .out_word_valid  (out_word_valid),
    .out_status      (out_status),
    .out_pad_bytes   (out_pad_bytes)
  );

endmodule

// ----- design/pgcf_front.sv -----
// Front end: accepts items, keeps the pixel and byte counters, classifies each command.
module pgcf_front #(
  parameter int COUNT_BITS = pgcf_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pgcf_pkg::cfg_t      cfg,
  input  logic                cfg_wr,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic signed [31:0]  in_raw_pixel,
  input  logic                q_full,
  output logic                q_push,
  output pgcf_pkg::q_entry_t  q_data
);
  import pgcf_pkg::*;

  localparam int CMP_BITS = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
  localparam logic [CMP_BITS-1:0] CNT_MASK = {CMP_BITS{1'b1}} >> (CMP_BITS - COUNT_BITS);

  logic [PROD_BITS-1:0]  prod_r, prod_nxt;
  logic [CMP_BITS-1:0]   total_r, total_nxt;
  logic [TOTAL_BITS-1:0] total_full;
  logic [CMP_BITS-1:0]   total_ext;
  logic [1:0]            settle_r, settle_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [OFF_BITS-1:0]   off_r, off_nxt;
  logic                  accept;
  logic                  cube_full;

  // Cube total in two multiply stages, clamped to the counter range
  always_comb begin
    prod_nxt   = PROD_BITS'(cfg.frame_width) * PROD_BITS'(cfg.frame_height);
    total_full = TOTAL_BITS'(prod_r) * TOTAL_BITS'(cfg.frame_count);
    total_ext  = CMP_BITS'(total_full);
    total_nxt  = (total_ext > CNT_MASK) ? CNT_MASK : total_ext;
  end

  // Hold off items until the total follows a configuration write
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_wr) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end
  end

  assign in_ready  = !q_full && (settle_r == 2'd0);
  assign accept    = in_valid && in_ready;
  assign cube_full = (CMP_BITS'(count_r) >= total_r);

  // Classify the command and advance the counters
  always_comb begin
    count_nxt       = count_r;
    off_nxt         = off_r;
    q_push          = accept;
    q_data.is_pixel = 1'b0;
    q_data.raw      = in_raw_pixel;
    q_data.status   = STAT_OK;
    q_data.pad      = '0;
    if (accept) begin
      case (in_opcode)
        OP_START: begin
          count_nxt = '0;
          off_nxt   = '0;
        end
        OP_PIXEL: begin
          if (cube_full) begin
            q_data.status = STAT_EXTRA;
          end else begin
            q_data.is_pixel = 1'b1;
            count_nxt       = count_r + COUNT_BITS'(1);
            off_nxt         = (off_r == BLOCK_BYTES_W - WORD_BYTES) ? '0 : off_r + WORD_BYTES;
          end
        end
        OP_END: begin
          if (!cube_full) begin
            q_data.status = STAT_SHORT;
          end else begin
            q_data.pad = (off_r == '0) ? '0 : BLOCK_BYTES_W - off_r;
          end
        end
        default: begin
          // unused code: plain all-zero result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r   <= '0;
      total_r  <= '0;
      settle_r <= '0;
      count_r  <= '0;
      off_r    <= '0;
    end else begin
      prod_r   <= prod_nxt;
      total_r  <= total_nxt;
      settle_r <= settle_nxt;
      count_r  <= count_nxt;
      off_r    <= off_nxt;
    end
  end

endmodule

// ----- design/pgcf_queue.sv -----
// Short queue of classified commands between front and back.
module pgcf_queue #(
  parameter int QUEUE_DEPTH = pgcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pgcf_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output pgcf_pkg::q_entry_t head
);
  import pgcf_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] DEPTH_W  = CNT_BITS'(QUEUE_DEPTH);

  q_entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;

  assign full      = (count_r == DEPTH_W);
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_BITS'(1);
      2'b01:   count_nxt = count_r - CNT_BITS'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- design/pgcf_back.sv -----
// Back end: gain divide, clamp and FITS scaling on a shared radix-4 divider, output register.
module pgcf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pgcf_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  pgcf_pkg::q_entry_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_scaled_word,
  output logic               out_word_valid,
  output logic [1:0]         out_status,
  output logic [11:0]        out_pad_bytes
);
  import pgcf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Two quotient bits per cycle: 32-bit gain pass, 26-bit scale pass
  localparam logic [3:0] DIV1_LAST = 4'd15;
  localparam logic [3:0] DIV2_LAST = 4'd12;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] shreg_r, shreg_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] word_r, word_nxt;
  logic        wvalid_r, wvalid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [11:0] pad_r, pad_nxt;

  logic        out_free;
  logic [15:0] gain_eff, scale_eff, dvs;
  logic [16:0] s1, s2;
  logic [15:0] u;
  logic signed [17:0] diff;
  logic [16:0] mag;
  logic [25:0] qmag;
  logic [15:0] word_pix;

  // One restoring step: returns {remainder, quotient bit}
  function automatic logic [16:0] div_step(input logic [15:0] rem, input logic din,
                                           input logic [15:0] d);
    logic [16:0] t;
    t = {rem, din};
    if (t >= {1'b0, d}) begin
      div_step = {16'(t - {1'b0, d}), 1'b1};
    end else begin
      div_step = {t[15:0], 1'b0};
    end
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign gain_eff  = (cfg.software_gain == '0) ? 16'd1 : cfg.software_gain;
  assign scale_eff = (cfg.scale_q8 == '0) ? 16'd1 : cfg.scale_q8;
  assign dvs       = (state_r == S_DIV1) ? gain_eff : scale_eff;

  // Shared divider datapath, two steps a cycle
  always_comb begin
    s1 = div_step(rem_r, shreg_r[31], dvs);
    s2 = div_step(s1[16:1], shreg_r[30], dvs);
  end

  // Clamp the gain quotient and form the scaling numerator magnitude
  always_comb begin
    u    = (|shreg_r[30:16]) ? 16'hFFFF : shreg_r[15:0];
    diff = $signed({2'b00, u}) - $signed({cfg.zero_offset[16], cfg.zero_offset});
    mag  = diff[17] ? 17'(-diff) : diff[16:0];
  end

  // Floor on negative numerators, then saturate to int16
  always_comb begin
    qmag = {1'b0, shreg_r[24:0]};
    if (neg_r) begin
      qmag = {1'b0, shreg_r[24:0]} + 26'(rem_r != '0);
      word_pix = (qmag > 26'd32768) ? 16'h8000 : 16'(26'd0 - qmag);
    end else begin
      word_pix = (qmag > 26'd32767) ? 16'h7FFF : qmag[15:0];
    end
  end

  // Sequence one command at a time
  always_comb begin
    state_nxt     = state_r;
    shreg_nxt     = shreg_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    word_nxt      = word_r;
    wvalid_nxt    = wvalid_r;
    status_nxt    = status_r;
    pad_nxt       = pad_r;
    q_pop         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_head.is_pixel) begin
            q_pop     = 1'b1;
            rem_nxt   = '0;
            cnt_nxt   = DIV1_LAST;
            shreg_nxt = q_head.raw[31] ? '0 : q_head.raw;
            state_nxt = q_head.raw[31] ? S_PREP : S_DIV1;
          end else if (out_free) begin
            q_pop         = 1'b1;
            out_valid_nxt = 1'b1;
            word_nxt      = '0;
            wvalid_nxt    = 1'b0;
            status_nxt    = q_head.status;
            pad_nxt       = q_head.pad;
          end
        end
      end
      S_DIV1: begin
        shreg_nxt = {shreg_r[29:0], s1[0], s2[0]};
        rem_nxt   = s2[16:1];
        cnt_nxt   = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        shreg_nxt = {1'b0, mag, 8'd0, 6'd0};
        rem_nxt   = '0;
        cnt_nxt   = DIV2_LAST;
        neg_nxt   = diff[17];
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        shreg_nxt = {shreg_r[29:0], s1[0], s2[0]};
        rem_nxt   = s2[16:1];
        cnt_nxt   = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          word_nxt      = word_pix;
          wvalid_nxt    = 1'b1;
          status_nxt    = STAT_OK;
          pad_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r  <= shreg_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    word_r   <= word_nxt;
    wvalid_r <= wvalid_nxt;
    status_r <= status_nxt;
    pad_r    <= pad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_scaled_word = $signed(word_r);
  assign out_word_valid  = wvalid_r;
  assign out_status      = status_r;
  assign out_pad_bytes   = pad_r;

  // Commands leave the queue only between pixels
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE))
    else $error("queue popped while a pixel is in progress");

  // Divider passes count down one step a cycle
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV1 || state_r == S_DIV2) && cnt_r != '0) |=>
      (state_r == $past(state_r) && cnt_r == $past(cnt_r) - 4'd1))
    else $error("divider pass left early or skipped a step");

  // A finished pixel lands in the output register
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && wvalid_r && state_r == S_IDLE))
    else $error("finished pixel not loaded");

  // A pixel word never carries a status or padding
  a_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && wvalid_r) |-> (status_r == STAT_OK && pad_r == '0))
    else $error("pixel result with nonzero status or padding");

endmodule

// ----- verif/tb.sv -----
// Testbench for the pixel gain, clamp and FITS 16-bit scaler: random cubes checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import pgcf_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT  = 4000;
  localparam int ITEM_TARGET  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int BIG_CUBE     = 700;
  localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [15:0] word;
    logic        valid;
    logic [1:0]  status;
    logic [11:0] pad;
  } fits_result_t;

  // Predicts each result item from its own copy of registers and counters
  class fits_word_checker;
    logic [15:0]        gain;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [15:0]        frames;
    logic signed [16:0] zero;
    logic [15:0]        scale;
    longint unsigned    pixel_count;
    int                 byte_offset;
    fits_result_t       expected_q[$];
    int                 mismatches;
    int                 results_seen;

    function new();
      gain = GAIN_RST;
      width = WIDTH_RST;
      height = HEIGHT_RST;
      frames = FRAMES_RST;
      zero = ZERO_RST;
      scale = SCALE_RST;
      pixel_count = 0;
      byte_offset = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [16:0] data);
      case (idx)
        CFG_GAIN:   gain = data[15:0];
        CFG_WIDTH:  width = data[14:0];
        CFG_HEIGHT: height = data[14:0];
        CFG_FRAMES: frames = data[15:0];
        CFG_ZERO:   zero = data;
        CFG_SCALE:  scale = data[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned cube_total();
      longint unsigned t;
      t = 64'(width) * 64'(height) * 64'(frames);
      if (t > COUNT_LIMIT) t = COUNT_LIMIT;
      return t;
    endfunction

    // Divide by gain, clamp to 16 bits, then floor((u - bzero) * 256 / scale) saturated
    function logic [15:0] fits_word(logic signed [31:0] raw);
      longint g, d, u, num, q;
      g = (gain == 0) ? 1 : longint'(gain);
      d = (scale == 0) ? 1 : longint'(scale);
      if (raw < 0) begin
        u = 0;
      end else begin
        u = longint'(raw) / g;
        if (u > 65535) u = 65535;
      end
      num = (u - longint'(zero)) * 256;
      if (num >= 0) q = num / d;
      else q = -((-num + d - 1) / d);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_item(logic [1:0] op, logic signed [31:0] raw);
      fits_result_t r;
      longint unsigned total;
      r = '0;
      total = cube_total();
      case (op)
        OP_START: begin
          pixel_count = 0;
          byte_offset = 0;
        end
        OP_PIXEL: begin
          if (pixel_count >= total) begin
            r.status = STAT_EXTRA;
          end else begin
            r.word = fits_word(raw);
            r.valid = 1'b1;
            pixel_count++;
            byte_offset = (byte_offset + 2) % BLOCK_BYTES;
          end
        end
        OP_END: begin
          if (pixel_count < total) r.status = STAT_SHORT;
          else r.pad = 12'((BLOCK_BYTES - byte_offset) % BLOCK_BYTES);
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("%0t: result %0d: %s", $time, results_seen, msg);
      mismatches++;
    endtask

    task check_result(logic [15:0] word, logic valid, logic [1:0] status, logic [11:0] pad);
      fits_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with no item waiting");
      end else begin
        e = expected_q.pop_front();
        if (word !== e.word)
          report($sformatf("scaled_word %0d, expected %0d", $signed(word), $signed(e.word)));
        if (valid !== e.valid)
          report($sformatf("word_valid %0d, expected %0d", valid, e.valid));
        if (status !== e.status)
          report($sformatf("status %0d, expected %0d", status, e.status));
        if (pad !== e.pad)
          report($sformatf("pad_bytes %0d, expected %0d", pad, e.pad));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = OP_START;
  logic signed [31:0] in_raw_pixel = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_scaled_word;
  logic               out_word_valid;
  logic [1:0]         out_status;
  logic [11:0]        out_pad_bytes;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = CFG_GAIN;
  logic [16:0]        cfg_data = '0;

  fits_word_checker chk;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit sender_calm = 1'b0;

  pixel_gain_clamp_fits_scaler dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_raw_pixel   (in_raw_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_scaled_word(out_scaled_word),
    .out_word_valid (out_word_valid),
    .out_status     (out_status),
    .out_pad_bytes  (out_pad_bytes),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick a raw pixel: full range, negatives, extremes, or values around the gain
  function automatic logic signed [31:0] rand_raw();
    longint g, v;
    g = (chk.gain == 0) ? 1 : longint'(chk.gain);
    case ($urandom_range(0, 9))
      0, 1: return 32'($urandom);
      2: return -32'sd1 * 32'($urandom_range(1, 1000));
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'sh80000000;
          1: return -32'sd1;
          2: return 32'sd0;
          default: return 32'sh7fffffff;
        endcase
      end
      default: begin
        v = longint'($urandom_range(0, 66000)) * g + longint'($urandom_range(0, 32'(g - 1)));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        return v[31:0];
      end
    endcase
  endfunction

  // Compare results, track predictions and config writes, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        chk.check_result(out_scaled_word, out_word_valid, out_status, out_pad_bytes);
      if (in_valid && in_ready) chk.note_item(in_opcode, in_raw_pixel);
      if (cfg_valid && cfg_ready) chk.write_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stall the result side at random, with long stretches of no stall
  initial begin
    int busy;
    int pause;
    forever begin
      busy = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (busy) @(posedge clk);
      pause = gap_len();
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic signed [31:0] raw);
    int pause;
    pause = sender_calm ? 0 : gap_len();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_raw_pixel <= raw;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Hold input and wait until every predicted result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic setup_cube(input logic [16:0] gain, input logic [16:0] width,
                            input logic [16:0] height, input logic [16:0] frames,
                            input logic [16:0] zero, input logic [16:0] scale);
    drain();
    cfg_write(CFG_GAIN, gain);
    cfg_write(CFG_WIDTH, width);
    cfg_write(CFG_HEIGHT, height);
    cfg_write(CFG_FRAMES, frames);
    cfg_write(CFG_ZERO, zero);
    cfg_write(CFG_SCALE, scale);
    // unused indexes must leave every register alone
    if ($urandom_range(0, 3) == 0)
      cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 17'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setup();
    logic [15:0] g, f, s;
    logic [14:0] w, h;
    logic [16:0] z;
    case ($urandom_range(0, 5))
      0: g = 16'd1;
      1: g = 16'd0;
      2: g = 16'hffff;
      3: g = 16'($urandom_range(2, 16));
      default: g = 16'($urandom);
    endcase
    w = ($urandom_range(0, 19) == 0) ? 15'd0 : 15'($urandom_range(1, 4));
    h = ($urandom_range(0, 19) == 0) ? 15'd0 : 15'($urandom_range(1, 3));
    f = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
    case ($urandom_range(0, 5))
      0: z = 17'd32768;
      1: z = 17'd0;
      2: z = 17'h10000;
      3: z = 17'd65535;
      default: z = 17'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: s = 16'd256;
      1: s = 16'd0;
      2: s = 16'd1;
      3: s = 16'hffff;
      4: s = 16'($urandom_range(1, 1024));
      default: s = 16'($urandom);
    endcase
    setup_cube({1'($urandom), g}, {2'($urandom), w}, {2'($urandom), h},
               {1'($urandom), f}, z, {1'($urandom), s});
  endtask

  // One cube, mostly well formed with counts off by one or two, else random commands
  task automatic run_cube(input bit whole);
    longint unsigned total;
    int n;
    total = chk.cube_total();
    if (whole || $urandom_range(0, 99) < 85) begin
      send_item(OP_START, rand_raw());
      if (total > BIG_CUBE) begin
        n = $urandom_range(5, 30);
      end else begin
        n = int'(total);
        if (!whole) begin
          case ($urandom_range(0, 9))
            0: if (n > 0) n--;
            1: n++;
            2: n += 2;
            default: ;
          endcase
        end
      end
      repeat (n) send_item(OP_PIXEL, rand_raw());
      send_item(OP_END, rand_raw());
      if ($urandom_range(0, 4) == 0) send_item(OP_END, rand_raw());
      if ($urandom_range(0, 6) == 0) send_item(OP_PIXEL, rand_raw());
    end else begin
      repeat ($urandom_range(1, 5)) send_item(2'($urandom_range(0, 3)), rand_raw());
    end
    if ($urandom_range(0, 9) == 0) drain();
  endtask

  initial begin
    int phase;
    chk = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings give an empty cube: pixel before start is extra, end pads nothing
    send_item(OP_PIXEL, 32'sd5);
    send_item(OP_END, 32'($urandom));
    send_item(OP_UNUSED, 32'($urandom));

    // Six-pixel cube with extreme raw values, short end, extra pixel, repeated end
    setup_cube(17'd1, 17'd3, 17'd1, 17'd2, 17'd32768, 17'd256);
    send_item(OP_START, 32'($urandom));
    send_item(OP_PIXEL, 32'sh80000000);
    send_item(OP_PIXEL, -32'sd1);
    send_item(OP_PIXEL, 32'sd0);
    send_item(OP_PIXEL, 32'sd65535);
    send_item(OP_PIXEL, 32'sh7fffffff);
    send_item(OP_END, 32'($urandom));
    send_item(OP_PIXEL, 32'sd40000);
    send_item(OP_PIXEL, 32'sd1);
    send_item(OP_END, 32'($urandom));
    send_item(OP_END, 32'($urandom));
    send_item(OP_START, 32'($urandom));
    send_item(OP_END, 32'($urandom));

    // Zero gain and zero scale, most negative bzero: saturate high
    setup_cube(17'd0, 17'd1, 17'd1, 17'd1, 17'h10000, 17'd0);
    send_item(OP_START, 32'($urandom));
    send_item(OP_PIXEL, 32'sd100);
    send_item(OP_END, 32'($urandom));

    // Largest gain, unit scale, largest bzero: saturate low
    setup_cube(17'd65535, 17'd2, 17'd1, 17'd1, 17'd65535, 17'd1);
    send_item(OP_START, 32'($urandom));
    send_item(OP_PIXEL, 32'sh7fffffff);
    send_item(OP_PIXEL, 32'sd0);
    send_item(OP_END, 32'($urandom));

    // Random phases, with one mid-size cube and two settings whose cubes are too large to finish
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      case (phase)
        3: begin
          setup_cube(17'd1, 17'd25, 17'd8, 17'd3, 17'd32768, 17'd256);
          run_cube(1'b1);
        end
        6: begin
          setup_cube(17'($urandom), 17'd32767, 17'd32767, 17'd65535, 17'($urandom),
                     17'($urandom));
          repeat (3) run_cube(1'b0);
        end
        9: begin
          setup_cube(17'($urandom), 17'd16384, 17'd16384, 17'd65535, 17'($urandom),
                     17'($urandom));
          repeat (2) run_cube(1'b0);
        end
        default: begin
          random_setup();
          repeat ($urandom_range(4, 10)) run_cube(1'b0);
        end
      endcase
      phase++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
